@@ rtl/rgb2hsl_pkg.sv @@
`timescale 1ns / 1ps

package rgb2hsl_pkg;

	// Default number of fraction bits in every result.
	localparam int unsigned FRACTION_BITS_DEF = 6;

	// Field widths.
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned HUE_W  = 15;
	localparam int unsigned PCT_W  = 13;

	// Widest divisor seen by the dividers: twice the largest denominator, 510.
	localparam int unsigned DEN_W = 9;

	// One input item: an RGB pixel.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// One result item: hue, saturation and lightness.
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] lightness;
	} hsl_t;

endpackage

@@ rtl/rgb2hsl_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// Each stage moves only when its enable is high, so the surrounding
// pipeline can stall any stage without losing data.
module rgb2hsl_div #(
	parameter int unsigned NUM_W = 24,
	parameter int unsigned DEN_W = rgb2hsl_pkg::DEN_W
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	// Per stage: partial remainder, a word holding the unused numerator bits
	// in its upper part and the quotient bits found so far in its lower part,
	// and the divisor.
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   trial;
		logic             fits;

		// Stage inputs come from the ports for the first stage.
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign nq_in  = nq_s[i-1];
			assign den_in = den_s[i-1];
		end

		// Bring down the next numerator bit and try one subtraction.
		always_comb begin
			trial = {rem_in, nq_in[NUM_W-1]};
			fits  = (trial >= {1'b0, den_in});
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				nq_s[i]  <= {nq_in[NUM_W-2:0], fits};
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

@@ rtl/rgb_to_hsl_convert.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// pix       in   pix_valid / pix_ready    rgb2hsl_pkg::pixel_t (red, green, blue)
// hsl       out  hsl_valid / hsl_ready    rgb2hsl_pkg::hsl_t (hue, saturation, lightness)
//
// One pixel is taken every cycle unless the pipeline is full and its output
// stalled. The pipeline holds the one-bit-per-stage hue and saturation dividers
// of FRACTION_BITS + 18 stages, plus two stages in front and one output stage.
// Lightness is a constant reciprocal multiplication that rides alongside them.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled output still lets
// new items in until the pipeline is full. Reset clears only the valid bits.
module rgb_to_hsl_convert #(
	parameter int unsigned FRACTION_BITS = rgb2hsl_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  rgb2hsl_pkg::pixel_t pix,
	output logic                hsl_valid,
	input  logic                hsl_ready,
	output rgb2hsl_pkg::hsl_t   hsl
);

	localparam int unsigned NUM_W = 18 + FRACTION_BITS;
	localparam int unsigned DEN_W = rgb2hsl_pkg::DEN_W;
	localparam int unsigned HUE_W = rgb2hsl_pkg::HUE_W;
	localparam int unsigned PCT_W = rgb2hsl_pkg::PCT_W;
	localparam int unsigned CH_W  = rgb2hsl_pkg::CHAN_W;
	localparam int unsigned LAT   = NUM_W + 3;
	localparam int unsigned OUT_STAGE = LAT - 1;
	localparam int unsigned DIV_LAST  = LAT - 2;

	localparam logic [NUM_W-1:0] HUE_TURN = NUM_W'(360 * (1 << FRACTION_BITS));
	localparam logic [NUM_W-1:0] PCT_FULL = NUM_W'(100 * (1 << FRACTION_BITS));

	// Lightness is floor((50 * scale * sum + 127) / 255), taken as a product with
	// a rounded-up reciprocal of 255 that is exact over the whole numerator range.
	localparam int unsigned LX_W = 15 + FRACTION_BITS;
	localparam int unsigned L_SH = LX_W + 8;
	localparam int unsigned LP_W = 2 * LX_W + 1;
	localparam logic [LP_W-1:0] L_RECIP = LP_W'(((64'd1 << L_SH) + 64'd254) / 64'd255);
	localparam logic [LP_W-1:0] L_MUL_A = LP_W'(50 * (1 << FRACTION_BITS)) * L_RECIP;
	localparam logic [LP_W-1:0] L_MUL_B = LP_W'(127) * L_RECIP;
	localparam logic [LX_W-1:0] LIGHT_FULL = LX_W'(100 * (1 << FRACTION_BITS));

	// Hue sector, named after the channel that holds the maximum.
	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	logic [LAT-1:0] vld_q;
	logic [LAT-1:0] adv;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		adv[LAT-1] = ~vld_q[LAT-1] | hsl_ready;
		for (int k = LAT - 2; k >= 0; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign pix_ready = adv[0];
	assign hsl_valid = vld_q[OUT_STAGE];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= pix_valid;
			end
			for (int k = 1; k < LAT; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: find maximum and minimum, the sector and the hue difference term.
	logic [CH_W-1:0]   mx;
	logic [CH_W-1:0]   mn;
	logic [1:0]        sect;
	logic signed [8:0] hdiff;

	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			mx    = pix.red;
			sect  = SECT_RED;
			hdiff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
		end else if (pix.green >= pix.blue) begin
			mx    = pix.green;
			sect  = SECT_GREEN;
			hdiff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
		end else begin
			mx    = pix.blue;
			sect  = SECT_BLUE;
			hdiff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
		end
		mn = pix.red;
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.blue < mn) begin
			mn = pix.blue;
		end
	end

	logic [CH_W-1:0]   d_s1;
	logic [CH_W:0]     sum_s1;
	logic [1:0]        sect_s1;
	logic signed [8:0] hdiff_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			d_s1     <= mx - mn;
			sum_s1   <= {1'b0, mx} + {1'b0, mn};
			sect_s1  <= sect;
			hdiff_s1 <= hdiff;
		end
	end

	// Stage 2: build rounding numerators and doubled divisors for the dividers,
	// and the finished lightness.
	// A grey pixel divides zero by two so that hue and saturation come out 0.
	logic signed [19:0] hd20;
	logic signed [19:0] dd20;
	logic signed [19:0] hoff;
	logic signed [19:0] hnum_raw;
	logic [16:0]        hnum;
	logic               grey;
	logic [CH_W:0]      sat_den;
	logic [LP_W-1:0]    lprod;
	logic [LX_W-1:0]    light_full;

	always_comb begin
		hd20 = {{11{hdiff_s1[8]}}, hdiff_s1};
		dd20 = $signed({12'b0, d_s1});
		case (sect_s1)
			SECT_RED:   hoff = 20'sd0;
			SECT_GREEN: hoff = 20'sd120 * dd20;
			SECT_BLUE:  hoff = 20'sd240 * dd20;
			default:    hoff = 20'sd0;
		endcase
		hnum_raw = 20'sd60 * hd20 + hoff;
		if (hnum_raw < 20'sd0) begin
			hnum_raw = hnum_raw + 20'sd360 * dd20;
		end
		hnum    = hnum_raw[16:0];
		grey    = (d_s1 == '0);
		sat_den = (sum_s1 <= 9'd255) ? sum_s1 : 9'd510 - sum_s1;
		lprod      = LP_W'(sum_s1) * L_MUL_A + L_MUL_B;
		light_full = LX_W'(lprod >> L_SH);
	end

	logic [NUM_W-1:0] hnum_s2;
	logic [DEN_W-1:0] hden_s2;
	logic [NUM_W-1:0] snum_s2;
	logic [DEN_W-1:0] sden_s2;
	logic [PCT_W-1:0] light_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			if (grey) begin
				hnum_s2 <= '0;
				hden_s2 <= DEN_W'(2);
				snum_s2 <= '0;
				sden_s2 <= DEN_W'(2);
			end else begin
				hnum_s2 <= (NUM_W'(hnum) << (FRACTION_BITS + 1)) + NUM_W'(d_s1);
				hden_s2 <= DEN_W'({d_s1, 1'b0});
				snum_s2 <= ((NUM_W'(d_s1) * NUM_W'(200)) << FRACTION_BITS) + NUM_W'(sat_den);
				sden_s2 <= DEN_W'({sat_den, 1'b0});
			end
			light_s2 <= light_full[PCT_W-1:0];
		end
	end

	// Two dividers in step, for hue and saturation.
	logic [NUM_W-1:0] quo_h;
	logic [NUM_W-1:0] quo_s;

	rgb2hsl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_hue (
		.clk (clk),
		.en  (adv[NUM_W+1:2]),
		.num (hnum_s2),
		.den (hden_s2),
		.quo (quo_h)
	);

	rgb2hsl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_sat (
		.clk (clk),
		.en  (adv[NUM_W+1:2]),
		.num (snum_s2),
		.den (sden_s2),
		.quo (quo_s)
	);

	// Lightness is carried alongside the divider stages.
	logic [PCT_W-1:0] light_dly [NUM_W];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			light_dly[0] <= light_s2;
		end
		for (int i = 1; i < NUM_W; i++) begin
			if (adv[i+2]) begin
				light_dly[i] <= light_dly[i-1];
			end
		end
	end

	// Output stage: a hue that rounds to a full turn wraps to zero.
	logic [HUE_W-1:0] hue_s3;
	logic [PCT_W-1:0] sat_s3;
	logic [PCT_W-1:0] light_s3;

	always_ff @(posedge clk) begin
		if (adv[OUT_STAGE]) begin
			hue_s3   <= (quo_h >= HUE_TURN) ? '0 : quo_h[HUE_W-1:0];
			sat_s3   <= quo_s[PCT_W-1:0];
			light_s3 <= light_dly[NUM_W-1];
		end
	end

	assign hsl.hue        = hue_s3;
	assign hsl.saturation = sat_s3;
	assign hsl.lightness  = light_s3;

`ifndef SYNTHESIS
	// Input is held off only while the output is full and stalled.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (hsl_valid && !hsl_ready))
		else $error("input refused while output can drain");

	// Rounded quotients stay within their ranges.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_LAST] |-> (quo_h <= HUE_TURN))
		else $error("hue quotient beyond a full turn");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_LAST] |-> (quo_s <= PCT_FULL))
		else $error("saturation quotient above 100 percent");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> (light_full <= LIGHT_FULL))
		else $error("lightness above 100 percent");
`endif

endmodule

@@ dv/rgb_to_hsl_convert_tb.sv @@
`timescale 1ns / 1ps

// Keeps the expected HSL results of the accepted pixels in order and checks the
// output items against them.
class hsl_scoreboard;
	rgb2hsl_pkg::hsl_t hsl_due[$];
	int failures;
	int pixels_seen;
	int results_seen;
	int grey_pixels;
	int midpoint_pixels;

	function new();
		failures = 0;
		pixels_seen = 0;
		results_seen = 0;
		grey_pixels = 0;
		midpoint_pixels = 0;
	endfunction

	// Exact integer conversion, rounded to nearest with halves rounded up.
	function rgb2hsl_pkg::hsl_t convert_pixel(rgb2hsl_pkg::pixel_t p);
		longint scale;
		longint r, g, b, mx, mn, spread, total, den, hnum, hue, sat, light;
		rgb2hsl_pkg::hsl_t res;
		scale = longint'(1) << rgb2hsl_pkg::FRACTION_BITS_DEF;
		r = longint'(p.red);
		g = longint'(p.green);
		b = longint'(p.blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		spread = mx - mn;
		total = mx + mn;
		light = (2 * 50 * scale * total + 255) / (2 * 255);
		hue = 0;
		sat = 0;
		if (spread != 0) begin
			// The midpoint itself still divides by the sum.
			den = (total <= 255) ? total : 510 - total;
			sat = (2 * 100 * scale * spread + den) / (2 * den);
			// Red wins a tie for the largest channel, then green.
			if (mx == r)
				hnum = 60 * (g - b);
			else if (mx == g)
				hnum = 60 * (b - r) + 120 * spread;
			else
				hnum = 60 * (r - g) + 240 * spread;
			if (hnum < 0)
				hnum += 360 * spread;
			hue = (2 * hnum * scale + spread) / (2 * spread);
			// A full turn wraps round to zero.
			if (hue >= 360 * scale)
				hue = 0;
		end
		res.hue = hue[rgb2hsl_pkg::HUE_W-1:0];
		res.saturation = sat[rgb2hsl_pkg::PCT_W-1:0];
		res.lightness = light[rgb2hsl_pkg::PCT_W-1:0];
		return res;
	endfunction

	function void note_pixel(rgb2hsl_pkg::pixel_t p);
		rgb2hsl_pkg::hsl_t res;
		int mx;
		int mn;
		res = convert_pixel(p);
		hsl_due.push_back(res);
		pixels_seen++;
		mx = int'(p.red);
		mn = int'(p.red);
		if (int'(p.green) > mx) mx = int'(p.green);
		if (int'(p.blue) > mx) mx = int'(p.blue);
		if (int'(p.green) < mn) mn = int'(p.green);
		if (int'(p.blue) < mn) mn = int'(p.blue);
		if (mx == mn)
			grey_pixels++;
		else if (mx + mn == 255)
			midpoint_pixels++;
	endfunction

	function void check_result(rgb2hsl_pkg::hsl_t got);
		rgb2hsl_pkg::hsl_t want;
		results_seen++;
		if (hsl_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("Unexpected result: hue %0d sat %0d light %0d",
					got.hue, got.saturation, got.lightness);
			return;
		end
		want = hsl_due.pop_front();
		if (got.hue !== want.hue || got.saturation !== want.saturation ||
				got.lightness !== want.lightness) begin
			failures++;
			if (failures <= 10)
				$display("Mismatch on result %0d: expected hue %0d sat %0d light %0d, got hue %0d sat %0d light %0d",
					results_seen, want.hue, want.saturation, want.lightness,
					got.hue, got.saturation, got.lightness);
		end
	endfunction

	function int pending();
		return hsl_due.size();
	endfunction
endclass

module rgb_to_hsl_convert_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int RANDOM_PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	rgb2hsl_pkg::pixel_t pix = '0;
	logic hsl_valid;
	logic hsl_ready = 1'b0;
	rgb2hsl_pkg::hsl_t hsl;

	hsl_scoreboard sb = new();
	int idle_pct = 0;
	int quiet_cycles = 0;

	rgb_to_hsl_convert dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.hsl_valid(hsl_valid),
		.hsl_ready(hsl_ready),
		.hsl(hsl)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offers one pixel, sometimes after an idle burst, and holds it until accepted.
	task send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		pix <= '{red: r, green: g, blue: b};
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
	endtask

	// Random pixel, weighted towards greys, tied channels and the lightness midpoint.
	function rgb2hsl_pkg::pixel_t random_pixel();
		logic [7:0] v[3];
		logic [7:0] t;
		int hi;
		int lo;
		int j;
		case ($urandom_range(0, 9))
			0: begin
				v[0] = 8'($urandom_range(0, 255));
				v[1] = v[0];
				v[2] = v[0];
			end
			1: begin
				hi = $urandom_range(1, 255);
				v[0] = 8'(hi);
				v[1] = 8'(hi);
				v[2] = 8'($urandom_range(0, hi - 1));
			end
			2: begin
				lo = $urandom_range(0, 254);
				v[0] = 8'(lo);
				v[1] = 8'(lo);
				v[2] = 8'($urandom_range(lo + 1, 255));
			end
			3: begin
				hi = $urandom_range(128, 255);
				v[0] = 8'(hi);
				v[1] = 8'(255 - hi);
				v[2] = 8'($urandom_range(255 - hi, hi));
			end
			4: begin
				lo = $urandom_range(0, 250);
				v[0] = 8'(lo);
				v[1] = 8'(lo + $urandom_range(0, 5));
				v[2] = 8'(lo + $urandom_range(0, 5));
			end
			default: begin
				v[0] = 8'($urandom_range(0, 255));
				v[1] = 8'($urandom_range(0, 255));
				v[2] = 8'($urandom_range(0, 255));
			end
		endcase
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = v[i];
			v[i] = v[j];
			v[j] = t;
		end
		return '{red: v[0], green: v[1], blue: v[2]};
	endfunction

	// The receiver stalls in random bursts while idling is enabled.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				hsl_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			hsl_ready <= 1'b1;
		end
	end

	// Both handshakes are sampled here, and a run that stops moving is ended.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready)
				sb.note_pixel(pix);
			if (hsl_valid && hsl_ready)
				sb.check_result(hsl);
			if ((pix_valid && pix_ready) || (hsl_valid && hsl_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
				$display("FAIL rgb_to_hsl_convert");
				$finish;
			end
		end
	end

	initial begin
		rgb2hsl_pkg::pixel_t p;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pixels: corners of the cube, greys, ties, midpoint and near wrap.
		idle_pct = 20;
		send_rgb(8'd0, 8'd0, 8'd0);
		send_rgb(8'd255, 8'd255, 8'd255);
		send_rgb(8'd128, 8'd128, 8'd128);
		send_rgb(8'd255, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd0, 8'd255);
		send_rgb(8'd255, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd255);
		send_rgb(8'd255, 8'd0, 8'd255);
		send_rgb(8'd200, 8'd200, 8'd50);
		send_rgb(8'd50, 8'd200, 8'd200);
		send_rgb(8'd200, 8'd50, 8'd200);
		send_rgb(8'd200, 8'd55, 8'd100);
		send_rgb(8'd100, 8'd255, 8'd0);
		send_rgb(8'd1, 8'd255, 8'd0);
		send_rgb(8'd255, 8'd0, 8'd1);
		send_rgb(8'd0, 8'd1, 8'd255);
		send_rgb(8'd1, 8'd0, 8'd0);
		send_rgb(8'd254, 8'd255, 8'd254);
		send_rgb(8'd1, 8'd2, 8'd3);
		send_rgb(8'd254, 8'd253, 8'd252);
		send_rgb(8'hAA, 8'h55, 8'hAA);
		send_rgb(8'h55, 8'hAA, 8'h55);
		send_rgb(8'd127, 8'd128, 8'd0);

		// Let the pipeline drain completely before the random part.
		pix_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		// Random pixels in phases of differing idle pressure; the last phase has none.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			if (ph == RANDOM_PHASES - 1)
				idle_pct = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				p = random_pixel();
				send_rgb(p.red, p.green, p.blue);
			end
		end
		pix_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Checked %0d results from %0d pixels, %0d of them grey and %0d on the lightness midpoint.",
			sb.results_seen, sb.pixels_seen, sb.grey_pixels, sb.midpoint_pixels);
		$display("Idle bursts of up to 14 cycles were applied on both sides; %0d failures.",
			sb.failures);
		if (sb.failures == 0)
			$display("PASS rgb_to_hsl_convert");
		else
			$display("FAIL rgb_to_hsl_convert");
		$finish;
	end
endmodule
